// ----- rtl/pfe_pkg.sv -----
// Shared types and constants for the postfix expression evaluator.
// Holds the stack cell opcodes, the divider request/response structs and the character codes.
// No dependencies.
package pfe_pkg;

  localparam int STACK_DEPTH = 128;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // ASCII codes of the characters that mean something
  localparam logic [7:0] SYM_ZERO  = 8'h30;
  localparam logic [7:0] SYM_NINE  = 8'h39;
  localparam logic [7:0] SYM_PLUS  = 8'h2B;
  localparam logic [7:0] SYM_MINUS = 8'h2D;
  localparam logic [7:0] SYM_STAR  = 8'h2A;
  localparam logic [7:0] SYM_SLASH = 8'h2F;

  // Value returned by a pop from an empty stack
  localparam logic [7:0] EMPTY_POP = 8'hFF;

  // Status codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_UNDER = 2'd1;
  localparam logic [1:0] ERR_OVER  = 2'd2;
  localparam logic [1:0] ERR_DIVZ  = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_TAKE_UP,
    CELL_TAKE_DOWN
  } pfe_cell_op_t;

  typedef struct packed {
    logic       start;
    logic [7:0] dividend;
    logic [7:0] divisor;
  } pfe_div_req_t;

  typedef struct packed {
    logic       busy;
    logic       done;
    logic [7:0] quotient;
  } pfe_div_rsp_t;

endpackage

// ----- rtl/postfix_expression_evaluator.sv -----
// Postfix evaluator: a chain of stack cells (top at cell 0), an iterative divider, one sequencer.
// Takes one symbol at a time: in_ready is high only when idle, so a new digit, operator or ignored
// character is not taken before the last is done; a '/' with a nonzero divisor waits for the 8-step
// divider. An item marked last is followed by a pop of the result, which waits for a free output slot.
// Synchronous active-low reset empties the stack, clears the error status and out_valid; stack data is not cleared.
// Depends on pfe_pkg, pfe_cell and pfe_div.
module postfix_expression_evaluator
  import pfe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_symbol,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [7:0] out_value,
  output logic [1:0]        out_status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_OP,
    S_DIV,
    S_FIN
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       err_r, err_nxt;
  logic [7:0]       sym_r, sym_nxt;
  logic             last_r, last_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_value_r, out_value_nxt;
  logic [1:0]       out_status_r, out_status_nxt;

  logic [7:0]       cell_q [STACK_DEPTH];
  pfe_cell_op_t     op_top, op_rest;
  logic [7:0]       top_data;

  pfe_div_req_t     div_req;
  pfe_div_rsp_t     div_rsp;

  logic [7:0]       right_opnd, left_opnd;
  logic [15:0]      prod;
  logic             has_one, has_two, is_full;
  logic             is_digit, is_binop;
  logic             slot_free;

  // ---------------------------------------------------------------- stack chain
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [7:0]   up_in;
    logic [7:0]   down_in;
    pfe_cell_op_t cop;
    if (i == 0) begin : g_top
      assign up_in = top_data;
      assign cop   = op_top;
    end else begin : g_body
      assign up_in = cell_q[i-1];
      assign cop   = op_rest;
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign down_in = cell_q[i];
    end else begin : g_mid
      assign down_in = cell_q[i+1];
    end
    pfe_cell u_cell (
      .clk     (clk),
      .op      (cop),
      .up_in   (up_in),
      .down_in (down_in),
      .q       (cell_q[i])
    );
  end

  pfe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // ---------------------------------------------------------------- decode
  assign has_one    = (cnt_r != '0);
  assign has_two    = (cnt_r >= CNT_W'(2));
  assign is_full    = (cnt_r == CNT_W'(STACK_DEPTH));
  assign right_opnd = has_one ? cell_q[0] : EMPTY_POP;
  assign left_opnd  = has_two ? cell_q[1] : EMPTY_POP;
  assign prod       = {8'd0, left_opnd} * {8'd0, right_opnd};
  assign is_digit   = (sym_r >= SYM_ZERO) && (sym_r <= SYM_NINE);
  assign is_binop   = (sym_r == SYM_PLUS) || (sym_r == SYM_MINUS) ||
                      (sym_r == SYM_STAR) || (sym_r == SYM_SLASH);
  assign slot_free  = !out_valid_r || out_ready;

  function automatic logic [1:0] note_err(input logic [1:0] cur, input logic [1:0] code);
    note_err = (cur == ERR_NONE) ? code : cur;
  endfunction

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    err_nxt        = err_r;
    sym_nxt        = sym_r;
    last_nxt       = last_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    op_top         = CELL_HOLD;
    op_rest        = CELL_HOLD;
    top_data       = 8'd0;
    div_req        = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          sym_nxt   = in_symbol;
          last_nxt  = in_last;
          state_nxt = S_OP;
        end
      end

      S_OP: begin
        state_nxt = last_r ? S_FIN : S_IDLE;
        if (is_digit) begin
          if (is_full) begin
            err_nxt = note_err(err_r, ERR_OVER);
          end else begin
            top_data = sym_r - SYM_ZERO;
            op_top   = CELL_TAKE_UP;
            op_rest  = CELL_TAKE_UP;
            cnt_nxt  = cnt_r + CNT_W'(1);
          end
        end else if (is_binop) begin
          if (!has_two) begin
            err_nxt = note_err(err_r, ERR_UNDER);
          end
          if (sym_r == SYM_SLASH && right_opnd != 8'd0) begin
            // hand off to the divider, stack holds until the quotient is back
            div_req.start    = 1'b1;
            div_req.dividend = left_opnd;
            div_req.divisor  = right_opnd;
            state_nxt        = S_DIV;
          end else begin
            case (sym_r)
              SYM_PLUS:  top_data = left_opnd + right_opnd;
              SYM_MINUS: top_data = left_opnd - right_opnd;
              SYM_STAR:  top_data = prod[7:0];
              default:   top_data = 8'd0;
            endcase
            if (sym_r == SYM_SLASH && has_two) begin
              err_nxt = note_err(err_r, ERR_DIVZ);
            end
            // two pops and a push: net one pop with the new top
            op_top = CELL_TAKE_UP;
            if (has_two) begin
              op_rest = CELL_TAKE_DOWN;
              cnt_nxt = cnt_r - CNT_W'(1);
            end else begin
              cnt_nxt = CNT_W'(1);
            end
          end
        end
      end

      S_DIV: begin
        if (div_rsp.done) begin
          top_data  = div_rsp.quotient;
          op_top    = CELL_TAKE_UP;
          if (has_two) begin
            op_rest = CELL_TAKE_DOWN;
            cnt_nxt = cnt_r - CNT_W'(1);
          end else begin
            cnt_nxt = CNT_W'(1);
          end
          state_nxt = last_r ? S_FIN : S_IDLE;
        end
      end

      S_FIN: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = has_one ? cell_q[0] : EMPTY_POP;
          out_status_nxt = has_one ? err_r : note_err(err_r, ERR_UNDER);
          cnt_nxt        = '0;
          err_nxt        = ERR_NONE;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      err_r       <= ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sym_r        <= sym_nxt;
    last_r       <= last_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  // ---------------------------------------------------------------- checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.busy |-> state_r == S_DIV)
    else $error("divider running outside the divide state");

  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && slot_free) |=> (cnt_r == '0 && err_r == ERR_NONE && out_valid_r))
    else $error("final pop did not clear the stack and post a result");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != ERR_NONE && state_r != S_FIN) |=> err_r == $past(err_r))
    else $error("first error overwritten");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r && $stable(out_value_r))
    else $error("pending result lost");

endmodule

// ----- rtl/pfe_cell.sv -----
// One entry of the operand stack chain.
// Takes its neighbor's value on push or pop, or holds. Uses pfe_pkg.
module pfe_cell
  import pfe_pkg::*;
(
  input  logic         clk,
  input  pfe_cell_op_t op,
  input  logic [7:0]   up_in,
  input  logic [7:0]   down_in,
  output logic [7:0]   q
);

  logic [7:0] q_r;
  logic [7:0] q_nxt;

  always_comb begin
    case (op)
      CELL_TAKE_UP:   q_nxt = up_in;
      CELL_TAKE_DOWN: q_nxt = down_in;
      default:        q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

// ----- rtl/pfe_div.sv -----
// Iterative signed 8-bit divider, one quotient bit per cycle, truncating toward zero.
// Uses pfe_pkg for the request and response structs.
module pfe_div
  import pfe_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  pfe_div_req_t req,
  output pfe_div_rsp_t rsp
);

  logic       busy_r, busy_nxt;
  logic       done_r, done_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic [7:0] quo_r, quo_nxt;
  logic [7:0] dvs_r, dvs_nxt;
  logic       neg_r, neg_nxt;
  logic [8:0] rs;
  logic [8:0] diff;
  logic       ge;

  assign rs   = {rem_r, quo_r[7]};
  assign diff = rs - {1'b0, dvs_r};
  assign ge   = (rs >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    if (req.start) begin
      // load magnitudes; -128 maps to 128 unsigned
      busy_nxt = 1'b1;
      cnt_nxt  = 3'd0;
      rem_nxt  = 8'd0;
      quo_nxt  = req.dividend[7] ? 8'(-req.dividend) : req.dividend;
      dvs_nxt  = req.divisor[7] ? 8'(-req.divisor) : req.divisor;
      neg_nxt  = req.dividend[7] ^ req.divisor[7];
    end else if (busy_r) begin
      rem_nxt = ge ? diff[7:0] : rs[7:0];
      quo_nxt = {quo_r[6:0], ge};
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? 8'(-quo_r) : quo_r;

endmodule
